>>> hdl/chol_pkg.sv
// ----------------------------------------------------------------------------
// chol_pkg: shared types for the upper Cholesky factor unit
// Sequencer state codes.
// ----------------------------------------------------------------------------
package chol_pkg;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_DOT_RD,
        ST_DOT_MUL,
        ST_DOT_ACC,
        ST_A_RD,
        ST_DIFF,
        ST_SQRT,
        ST_DIV,
        ST_WRITE,
        ST_EMIT_RD,
        ST_EMIT,
        ST_FAIL
    } chol_state_t;

endpackage

>>> hdl/cholesky_upper_factor_unit.sv
// ----------------------------------------------------------------------------
// cholesky_upper_factor_unit: upper Cholesky factor, signed fixed point
// Loads the upper triangle row-major and factors A = U^T*U in place.
// ----------------------------------------------------------------------------
// Loading accepts one entry per cycle and busy stays low meanwhile. The final
// entry starts the factorisation and busy rises until the last result has
// gone. Each dot-product term passes through ST_DOT_RD, ST_DOT_MUL and
// ST_DOT_ACC, using the single memory read port and the one 32x32 multiplier;
// each square root and each division holds the shared bit-serial unit; every
// factor entry then reads, subtracts and writes back; emission reads and
// strobes each entry in ST_EMIT_RD and ST_EMIT. Results carry a one-cycle
// strobe and cannot be held off, so the receiver must take every strobed
// result. Writing the size register abandons any partial load.
module cholesky_upper_factor_unit #(
    parameter int MAX_ORDER = 8,
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] entry_value,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [3:0]         cfg_data,
    output logic               result_strobe,
    output logic signed [31:0] u_value,
    output logic [2:0]         row_index,
    output logic [2:0]         col_index,
    output logic [3:0]         fail_order,
    output logic               last_result
);
    import chol_pkg::*;

    localparam int IW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
    localparam int OW = $clog2(MAX_ORDER + 1);
    localparam int AW = 2 * IW;
    localparam int DEPTH = 1 << AW;
    localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
    localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};

    // storage: one array, one write and one read port
    logic signed [31:0] mem [DEPTH];
    logic [AW-1:0]      rd_addr;
    logic [AW-1:0]      wr_addr;
    logic signed [31:0] wr_data;
    logic               wr_en;
    logic signed [31:0] rd_data_reg;

    chol_state_t state_reg, state_next;
    logic [3:0]  size_reg;
    logic [OW-1:0] n_eff;
    logic [IW-1:0] lr_reg, lc_reg;      // load position
    logic [IW-1:0] j_reg, k_reg, i_reg; // factor position
    logic signed [31:0] op_a_reg;
    logic signed [63:0] prod_reg, acc_reg, diff_reg;
    logic [31:0] piv_reg;
    // bit-serial unit
    logic [63:0] rem_reg, x_reg;
    logic [63:0] q_reg;
    logic [6:0]  cnt_reg;
    logic        neg_reg;
    logic        ser_done;

    assign n_eff = (size_reg == 4'd0) ? OW'(1) :
                   ({1'b0, size_reg} > 5'(MAX_ORDER)) ? OW'(MAX_ORDER) : OW'(size_reg);

    logic last_col, last_row, in_xfer;
    assign last_col = ({1'b0, lc_reg} == (IW+1)'(n_eff - 1'b1));
    assign last_row = ({1'b0, lr_reg} == (IW+1)'(n_eff - 1'b1));
    assign in_xfer  = start && !busy;
    assign cfg_ready = !busy;
    assign busy = (state_reg != ST_LOAD);

    // saturating helpers
    function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
        logic signed [63:0] s;
        s = a + b;
        if (!a[63] && !b[63] && s[63]) return S64_MAX;
        if (a[63] && b[63] && !s[63]) return S64_MIN;
        return s;
    endfunction

    logic signed [63:0] a_scaled, sub_res;
    assign a_scaled = 64'(rd_data_reg) <<< FRAC_BITS;
    always_comb
    begin
        sub_res = a_scaled - acc_reg;
        if (!a_scaled[63] && acc_reg[63] && sub_res[63]) sub_res = S64_MAX;
        else if (a_scaled[63] && !acc_reg[63] && !sub_res[63]) sub_res = S64_MIN;
    end

    logic is_diag;
    assign is_diag = (k_reg == j_reg);
    // pivot not positive: the run stops here
    logic piv_bad;
    assign piv_bad = is_diag && (diff_reg <= 0 || q_reg == 64'd0);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:    if (in_xfer && last_col && last_row) state_next = ST_DOT_RD;
            ST_DOT_RD:  state_next = (i_reg == j_reg) ? ST_A_RD : ST_DOT_MUL;
            ST_DOT_MUL: state_next = ST_DOT_ACC;
            ST_DOT_ACC: state_next = ST_DOT_RD;
            ST_A_RD:    state_next = ST_DIFF;
            ST_DIFF:    state_next = is_diag ? ST_SQRT : ST_DIV;
            ST_SQRT:    if (ser_done) state_next = ST_WRITE;
            ST_DIV:     if (ser_done) state_next = ST_WRITE;
            ST_WRITE:
                if (piv_bad) state_next = ST_FAIL;
                else if ({1'b0, k_reg} == (IW+1)'(n_eff - 1'b1))
                    state_next = ({1'b0, j_reg} == (IW+1)'(n_eff - 1'b1)) ?
                                 ST_EMIT_RD : ST_DOT_RD;
                else state_next = ST_DOT_RD;
            ST_EMIT_RD: state_next = ST_EMIT;
            ST_EMIT:    state_next = (last_col && last_row) ? ST_LOAD : ST_EMIT_RD;
            ST_FAIL:    state_next = ST_LOAD;
            default:    state_next = ST_LOAD;
        endcase
    end

    // memory addressing
    always_comb
    begin
        wr_en = 1'b0;
        wr_addr = {lr_reg, lc_reg};
        wr_data = entry_value;
        rd_addr = {i_reg, j_reg};
        unique case (state_reg)
            ST_LOAD:    wr_en = in_xfer;
            ST_DOT_RD:  rd_addr = {i_reg, j_reg};
            ST_DOT_MUL: rd_addr = {i_reg, k_reg};
            ST_A_RD:    rd_addr = {j_reg, k_reg};
            ST_WRITE:
            begin
                wr_en = 1'b1;
                wr_addr = {j_reg, k_reg};
                if (is_diag)
                    wr_data = (q_reg > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : 32'(q_reg);
                else if (!neg_reg)
                    wr_data = (q_reg > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : 32'(q_reg);
                else
                    wr_data = (q_reg > 64'h8000_0000) ? 32'sh8000_0000 : 32'(-q_reg);
            end
            ST_EMIT_RD: rd_addr = {lr_reg, lc_reg};
            default:    rd_addr = {i_reg, j_reg};
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en) mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

    // bit-serial sqrt (2 bits/step, 32 steps) and divide (1 bit/step, 64 steps)
    logic [63:0] sq_trial, dv_rem;
    logic [65:0] sq_rem;
    always_comb
    begin
        sq_rem   = {rem_reg, x_reg[63:62]};
        sq_trial = {q_reg[61:0], 2'b01};
        dv_rem   = {rem_reg[62:0], x_reg[63]};
    end
    assign ser_done = (cnt_reg == 7'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            size_reg  <= 4'd8;
            lr_reg    <= '0;
            lc_reg    <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
            i_reg     <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                size_reg <= cfg_data;
                lr_reg <= '0;
                lc_reg <= '0;
            end
            else if ((state_reg == ST_LOAD && in_xfer) || state_reg == ST_EMIT)
            begin
                if (last_col)
                begin
                    lr_reg <= last_row ? '0 : lr_reg + 1'b1;
                    lc_reg <= last_row ? '0 : lr_reg + 1'b1;
                end
                else lc_reg <= lc_reg + 1'b1;
            end
            if (state_reg == ST_LOAD)
            begin
                j_reg <= '0; k_reg <= '0; i_reg <= '0;
            end
            if (state_reg == ST_DOT_ACC) i_reg <= i_reg + 1'b1;
            if (state_reg == ST_DIFF) cnt_reg <= is_diag ? 7'd32 : 7'd64;
            if ((state_reg == ST_SQRT || state_reg == ST_DIV) && !ser_done)
                cnt_reg <= cnt_reg - 1'b1;
            // a failed pivot keeps j for the failure result
            if (state_reg == ST_WRITE && !piv_bad)
            begin
                i_reg <= '0;
                if ({1'b0, k_reg} == (IW+1)'(n_eff - 1'b1))
                begin
                    j_reg <= j_reg + 1'b1;
                    k_reg <= j_reg + 1'b1;
                end
                else k_reg <= k_reg + 1'b1;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_LOAD:    acc_reg <= '0;
            ST_DOT_MUL: op_a_reg <= rd_data_reg;
            ST_DOT_ACC: prod_reg <= 64'(op_a_reg) * 64'(rd_data_reg);
            ST_DIFF:
            begin
                diff_reg <= sub_res;
                rem_reg  <= '0;
                q_reg    <= '0;
                x_reg    <= sub_res[63] ? 64'(-sub_res) : 64'(sub_res);
                neg_reg  <= sub_res[63] ^ piv_reg[31];
            end
            ST_SQRT:
                if (!ser_done)
                begin
                    x_reg <= {x_reg[61:0], 2'b00};
                    if (sq_rem >= {2'b00, sq_trial})
                    begin
                        rem_reg <= 64'(sq_rem - {2'b00, sq_trial});
                        q_reg   <= {q_reg[62:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= sq_rem[63:0];
                        q_reg   <= {q_reg[62:0], 1'b0};
                    end
                end
            ST_DIV:
                if (!ser_done)
                begin
                    x_reg <= {x_reg[62:0], 1'b0};
                    if (dv_rem >= {32'd0, piv_reg})
                    begin
                        rem_reg <= dv_rem - {32'd0, piv_reg};
                        q_reg   <= {q_reg[62:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= dv_rem;
                        q_reg   <= {q_reg[62:0], 1'b0};
                    end
                end
            ST_WRITE:
            begin
                acc_reg <= '0;
                if (is_diag) piv_reg <= wr_data;
            end
            default: ;
        endcase
        // each product from ST_DOT_ACC is summed in the following ST_DOT_RD,
        // including the last one before ST_A_RD
        if (state_reg == ST_DOT_RD && i_reg != '0)
            acc_reg <= sadd(acc_reg, prod_reg);
    end

    // result outputs
    always_comb
    begin
        result_strobe = 1'b0;
        u_value = '0;
        row_index = '0;
        col_index = '0;
        fail_order = '0;
        last_result = 1'b0;
        unique case (state_reg)
            ST_EMIT:
            begin
                result_strobe = 1'b1;
                u_value = rd_data_reg;
                row_index = 3'(lr_reg);
                col_index = 3'(lc_reg);
                last_result = last_col && last_row;
            end
            ST_FAIL:
            begin
                result_strobe = 1'b1;
                fail_order = 4'(j_reg) + 4'd1;
                last_result = 1'b1;
            end
            default: ;
        endcase
    end

    // checks
    a_no_cfg_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !cfg_ready) else $error("cfg ready while busy");
    a_fail_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && fail_order != 4'd0) |-> last_result)
        else $error("failure result not final");
    a_emit_done: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && last_result) |=> !busy) else $error("busy after last");
endmodule
